/* rtl/core/subset_sum_backtrack_search_assert.svh */
// ============================================================================
// Subset-sum search assertion macros
// Shared assertion forms for the subset-sum backtracking search. They expect
// i_clk and i_rst_n in the scope where they are used.
// ============================================================================
`ifndef SUBSET_SUM_BACKTRACK_SEARCH_ASSERT_SVH
`define SUBSET_SUM_BACKTRACK_SEARCH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ssbs_pkg.sv */
// ============================================================================
// Subset-sum search package
// Field widths, parameter defaults and the sequencer state type.
// ============================================================================
`timescale 1ns / 1ps

package ssbs_pkg;

    localparam int TARGET_W         = 20;
    localparam int FIELD_W          = 16;
    localparam int MAX_ELEMENTS_DEF = 16;
    localparam int VALUE_BITS_DEF   = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TRY,
        S_POP,
        S_RESTORE,
        S_EMIT_RD,
        S_EMIT,
        S_MISS
    } t_state;

endpackage

/* rtl/core/subset_sum_backtrack_search.sv */
// ============================================================================
// Subset-sum backtracking search
// Stores a set of element values and searches depth first for the first set
// of them, taken in ascending index order, whose sum equals the target.
// ============================================================================
// Usage:
// The target sum is written through i_cfg_we / i_cfg_data while the block is
// idle. Element values then arrive on the input channel, one word per cycle;
// a word is taken when i_in_valid is high and o_in_stall is low. The word
// carrying i_last_element starts the search, and o_in_stall stays high until
// every result of that run has been loaded into the output register.
// The search walks a pick stack: each candidate index takes a scan step for
// the element store read and a try step on the shared add/subtract unit, and
// each backtrack takes the scan that finds the level exhausted, the pick
// stack read, then the restore. The number of steps therefore ranges
// from a few per element to exponential in the number of stored elements.
// Results then leave one word at a time while the receiver does not stall:
// one word per picked element with found set, each read from the pick stack
// and then emitted, or a single word with found clear when no set exists.
// An output stall holds the output register and the sequencer when it emits.
// Reset is synchronous; it empties the element set, clears the target and
// drops any pending result. No clearing pass is needed after reset.
// ============================================================================
`timescale 1ns / 1ps

`include "subset_sum_backtrack_search_assert.svh"

module subset_sum_backtrack_search #(
    parameter int MAX_ELEMENTS = ssbs_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_BITS   = ssbs_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration: target sum
    input  logic                         i_cfg_we,
    input  logic [ssbs_pkg::TARGET_W-1:0] i_cfg_data,
    // Input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [ssbs_pkg::FIELD_W-1:0]  i_element_value,
    input  logic                         i_last_element,
    // Output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_found,
    output logic [ssbs_pkg::FIELD_W-1:0]  o_picked_value,
    output logic                         o_last_result
);

    import ssbs_pkg::*;

    // Counters must hold MAX_ELEMENTS itself; addresses only reach below it.
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int SUM_W = (VALUE_BITS > TARGET_W) ? VALUE_BITS : TARGET_W;

    // Element store and pick stack (index and value of each pick).
    logic [VALUE_BITS-1:0] r_store   [MAX_ELEMENTS];
    logic [IDX_W-1:0]      r_stk_idx [MAX_ELEMENTS];
    logic [VALUE_BITS-1:0] r_stk_val [MAX_ELEMENTS];

    logic [VALUE_BITS-1:0] r_store_rd;
    logic [IDX_W-1:0]      r_stk_rd_idx;
    logic [VALUE_BITS-1:0] r_stk_rd_val;

    t_state                r_state,     n_state;
    logic [TARGET_W-1:0]   r_target,    n_target;
    logic [TARGET_W-1:0]   r_rem,       n_rem;
    logic [CNT_W-1:0]      r_count,     n_count;
    logic [CNT_W-1:0]      r_idx,       n_idx;
    logic [CNT_W-1:0]      r_depth,     n_depth;
    logic [CNT_W-1:0]      r_out_ptr,   n_out_ptr;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_found, n_out_found;
    logic [FIELD_W-1:0]    r_out_value, n_out_value;
    logic                  r_out_last,  n_out_last;

    logic                  in_accept;
    logic                  store_we;
    logic                  push_en;
    logic                  out_free;
    logic [31:0]           in_ext;
    logic [31:0]           pick_ext;
    logic [CNT_W-1:0]      depth_m1;
    logic [IDX_W-1:0]      stk_raddr;

    // Shared add/subtract unit on the remaining sum.
    logic [VALUE_BITS-1:0] alu_b;
    logic                  alu_sub;
    logic [SUM_W:0]        alu_res;
    logic                  fits;
    logic                  hit;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign store_we  = in_accept && (r_count < CNT_W'(MAX_ELEMENTS));
    assign in_ext    = 32'(i_element_value);
    assign pick_ext  = 32'(r_stk_rd_val);
    assign depth_m1  = r_depth - CNT_W'(1);
    assign stk_raddr = (r_state == S_POP) ? depth_m1[IDX_W-1:0] : r_out_ptr[IDX_W-1:0];

    assign alu_sub = (r_state == S_TRY);
    assign alu_b   = alu_sub ? r_store_rd : r_stk_rd_val;
    assign alu_res = alu_sub ? ({1'b0, SUM_W'(r_rem)} - {1'b0, SUM_W'(alu_b)})
                             : ({1'b0, SUM_W'(r_rem)} + {1'b0, SUM_W'(alu_b)});
    // A borrow out of the subtraction means the candidate exceeds the rest.
    assign fits    = !alu_res[SUM_W];
    assign hit     = (alu_res == '0);

    always_comb begin
        n_state     = r_state;
        n_target    = r_target;
        n_rem       = r_rem;
        n_count     = r_count;
        n_idx       = r_idx;
        n_depth     = r_depth;
        n_out_ptr   = r_out_ptr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_found = r_out_found;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        push_en     = 1'b0;
        o_in_stall  = (r_state != S_IDLE);

        if (i_cfg_we) begin
            n_target = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (store_we) begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_last_element) begin
                        n_rem   = r_target;
                        n_idx   = '0;
                        n_depth = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // The store is read at r_idx at the end of this cycle.
                if (r_idx < r_count) begin
                    n_state = S_TRY;
                end else if (r_depth == '0) begin
                    n_state = S_MISS;
                end else begin
                    n_state = S_POP;
                end
            end
            S_TRY: begin
                n_idx   = r_idx + CNT_W'(1);
                n_state = S_SCAN;
                if (fits) begin
                    push_en = 1'b1;
                    n_depth = r_depth + CNT_W'(1);
                    n_rem   = alu_res[TARGET_W-1:0];
                    if (hit) begin
                        n_out_ptr = '0;
                        n_state   = S_EMIT_RD;
                    end
                end
            end
            S_POP: begin
                n_state = S_RESTORE;
            end
            S_RESTORE: begin
                n_rem   = alu_res[TARGET_W-1:0];
                n_idx   = CNT_W'(r_stk_rd_idx) + CNT_W'(1);
                n_depth = depth_m1;
                n_state = S_SCAN;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = 1'b1;
                    n_out_value = pick_ext[FIELD_W-1:0];
                    n_out_last  = ((r_out_ptr + CNT_W'(1)) == r_depth);
                    n_out_ptr   = r_out_ptr + CNT_W'(1);
                    if ((r_out_ptr + CNT_W'(1)) == r_depth) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_MISS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = 1'b0;
                    n_out_value = '0;
                    n_out_last  = 1'b1;
                    n_count     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= '0;
            r_rem       <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_depth     <= '0;
            r_out_ptr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_target    <= n_target;
            r_rem       <= n_rem;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_depth     <= n_depth;
            r_out_ptr   <= n_out_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_found <= n_out_found;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    // Element store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_count[IDX_W-1:0]] <= in_ext[VALUE_BITS-1:0];
        end
        r_store_rd <= r_store[r_idx[IDX_W-1:0]];
    end

    // Pick stack: pushed in the try step, read for backtracking and output.
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_stk_idx[r_depth[IDX_W-1:0]] <= r_idx[IDX_W-1:0];
            r_stk_val[r_depth[IDX_W-1:0]] <= r_store_rd;
        end
        r_stk_rd_idx <= r_stk_idx[stk_raddr];
        r_stk_rd_val <= r_stk_val[stk_raddr];
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_picked_value = r_out_value;
    assign o_last_result  = r_out_last;

    `SSBS_ASSERT_NOW(a_depth_le_count, (r_state != S_IDLE), (r_depth <= r_count), "pick stack deeper than element set")
    `SSBS_ASSERT_NOW(a_try_in_range, (r_state == S_TRY), (r_idx < r_count), "candidate index beyond element set")
    `SSBS_ASSERT_NOW(a_emit_rem_zero, (r_state == S_EMIT_RD), (r_rem == '0), "emitting a set that misses the target")
    `SSBS_ASSERT_NOW(a_miss_empty_stack, (r_state == S_MISS), (r_depth == '0), "no-solution result with picks on the stack")
    `SSBS_ASSERT_NEXT(a_last_ends_run, (r_state == S_EMIT && out_free && n_out_last), (r_state == S_IDLE && o_out_valid && o_last_result), "final result did not end the run")

endmodule
